FILE: rtl/wvg_pkg.sv
// Package for the waveform velocity generator.
// Holds configuration register indexes, port widths, reset values, parameter
// defaults and wave kind codes. Depends on nothing.
`timescale 1ns / 1ps

package wvg_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWaveKind    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAmplitude   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPhaseOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPointCount  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAngleStep   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInvTimeStep = 3'd5;

  // Output field widths.
  localparam int XVelW = 31;
  localparam int YVelW = 25;

  // Register reset values.
  localparam logic        [15:0] AmplitudeRst   = 16'sd256;
  localparam logic        [15:0] PointCountRst  = 16'd64;
  localparam logic        [23:0] AngleStepRst   = 24'd266305;
  localparam logic        [15:0] InvTimeStepRst = 16'd256;

  // Parameter defaults.
  localparam int TableDepthDef = 4096;
  localparam int AngleBitsDef  = 24;

  // Wave kind codes.
  localparam logic WaveSine   = 1'b0;
  localparam logic WaveSquare = 1'b1;

endpackage

FILE: rtl/waveform_velocity_generator.sv
// Top level of the waveform velocity generator: sequencer, shared multiplier,
// sine ROM and output register in one module.
// Depends on wvg_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  input   | in        | in_valid_i / in_stall_o   | restart_i
//  output  | out       | out_valid_o / out_stall_i | x_velocity_o, y_velocity_o, is_last_o
//  config  | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A regular point passes the states ANG, PH, RD0, RD1, W0, W1, DY, DX and OUT on its
// way to the output register, and the next transaction is accepted only once the
// sequencer is back in idle: five products go one after another through the single
// 25x25 multiplier and the two sine ROM reads share one registered read port. The
// last point of a period goes straight from idle to OUT. The ROM is a constant and
// needs no fill after reset.
// Reset clears the sequencer and point index and loads the configuration reset values.
// A stalled output holds its transaction; the sequencer then waits in its final
// step, and the input is accepted again once the result is in the output register.

module waveform_velocity_generator #(
  parameter int TABLE_DEPTH = wvg_pkg::TableDepthDef,
  parameter int ANGLE_BITS  = wvg_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [wvg_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wvg_pkg::CfgDataW-1:0]      cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wvg_pkg::XVelW-1:0]         x_velocity_o,
  output logic signed [wvg_pkg::YVelW-1:0]  y_velocity_o,
  output logic                              is_last_o
);

  import wvg_pkg::*;

  localparam int TableBits = $clog2(TABLE_DEPTH);
  localparam int IdxFullW  = ANGLE_BITS + TableBits;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ANG  = 4'd1;
  localparam logic [3:0] S_PH   = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_W0   = 4'd5;
  localparam logic [3:0] S_W1   = 4'd6;
  localparam logic [3:0] S_DY   = 4'd7;
  localparam logic [3:0] S_DX   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic signed [41:0] YMax = 42'sd16777215;
  localparam logic signed [41:0] YMin = -42'sd16777216;

  typedef logic signed [15:0] rom_t [TABLE_DEPTH];

  // One sine entry, round(32767*sin(2*pi*j/TABLE_DEPTH)), from a Q30 series.
  function automatic logic signed [15:0] table_value(input int unsigned j);
    logic [63:0] u, q, r, x, x2, term, s;
    logic        neg;
    u = 64'(j) * 64'd4;
    q = u / TABLE_DEPTH;
    r = u % TABLE_DEPTH;
    if (q[0]) begin
      r = 64'(TABLE_DEPTH) - r;
    end
    x    = (r * HalfPiQ30) / TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    s    = x;
    term = ((term * x2) >> 30) / 6;
    s    = s - term;
    term = ((term * x2) >> 30) / 20;
    s    = s + term;
    term = ((term * x2) >> 30) / 42;
    s    = s - term;
    term = ((term * x2) >> 30) / 72;
    s    = s + term;
    term = ((term * x2) >> 30) / 110;
    s    = s - term;
    term = ((term * x2) >> 30) / 156;
    s    = s + term;
    term = ((term * x2) >> 30) / 210;
    s    = s - term;
    neg  = (q >= 64'd2);
    s    = (64'd32767 * s + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return neg ? -16'(s) : 16'(s);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      t[j] = table_value(j);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Wave value from a product amplitude*S and the table entry S.
  function automatic logic signed [16:0] wave_val(input logic               kind,
                                                  input logic signed [15:0] amp,
                                                  input logic signed [49:0] p,
                                                  input logic signed [15:0] s);
    logic signed [16:0] amp_w;
    amp_w = {amp[15], amp};
    if (kind == WaveSquare) begin
      if (s > 16'sd0) begin
        return amp_w;
      end else if (s < 16'sd0) begin
        return -amp_w;
      end
      return 17'sd0;
    end
    return p[31:15];
  endfunction

  // Configuration registers.
  logic                wave_kind_q;
  logic signed [15:0]  amp_q;
  logic        [23:0]  phase_q;
  logic        [15:0]  count_q;
  logic        [23:0]  step_q;
  logic        [15:0]  inv_q;

  // Control state.
  logic [3:0]  state_q, state_d;
  logic [15:0] point_idx_q;
  logic        out_valid_q;

  // Datapath registers.
  logic        [15:0]          i_q;
  logic                        last_q;
  logic signed [49:0]          p_q;
  logic        [ANGLE_BITS-1:0] ang_q;
  logic signed [15:0]          rom_q;
  logic signed [15:0]          s0_q;
  logic signed [16:0]          w0_q;
  logic signed [17:0]          d_q;
  logic signed [YVelW-1:0]     y_q;
  logic        [XVelW-1:0]     x_out_q;
  logic signed [YVelW-1:0]     y_out_q;
  logic                        last_out_q;

  // Shared multiplier operands.
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;

  logic                    in_acc;
  logic                    out_free;
  logic [15:0]             i_new;
  logic                    is_last_new;
  logic [ANGLE_BITS-1:0]   phase_ext, step_ext;
  logic [IdxFullW-1:0]     idx_full;
  logic [TableBits-1:0]    rom_addr;
  logic signed [16:0]      w1;
  logic signed [41:0]      y_wide;
  logic signed [YVelW-1:0] y_sat;
  logic [XVelW-1:0]        x_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign x_velocity_o = x_out_q;
  assign y_velocity_o = y_out_q;
  assign is_last_o    = last_out_q;

  // Point index for the incoming transaction and the last-point test.
  assign i_new       = restart_i ? 16'd0 : point_idx_q;
  assign is_last_new = ({1'b0, i_new} + 17'd1) >= {1'b0, count_q};

  // Angle operands at the angle width, and the table address scaled from the angle.
  assign phase_ext = ANGLE_BITS'(32'(phase_q));
  assign step_ext  = ANGLE_BITS'(32'(step_q));
  assign idx_full  = (IdxFullW'(ang_q) * IdxFullW'(TABLE_DEPTH)) >> ANGLE_BITS;
  assign rom_addr  = idx_full[TableBits-1:0];

  // Second wave value and result saturation.
  assign w1     = wave_val(wave_kind_q, amp_q, p_q, rom_q);
  assign y_wide = p_q[49:8];
  always_comb begin
    if (y_wide > YMax) begin
      y_sat = YMax[YVelW-1:0];
    end else if (y_wide < YMin) begin
      y_sat = YMin[YVelW-1:0];
    end else begin
      y_sat = y_wide[YVelW-1:0];
    end
  end
  assign x_sat = p_q[39] ? {XVelW{1'b1}} : p_q[38:8];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ANG: begin
        mul_a = {9'd0, i_q};
        mul_b = {1'b0, step_q};
      end
      S_RD1, S_W0: begin
        mul_a = {{9{amp_q[15]}}, amp_q};
        mul_b = {{9{rom_q[15]}}, rom_q};
      end
      S_DY: begin
        mul_a = {{7{d_q[17]}}, d_q};
        mul_b = {9'd0, inv_q};
      end
      S_DX: begin
        mul_a = {1'b0, step_q};
        mul_b = {9'd0, inv_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = is_last_new ? S_OUT : S_ANG;
        end
      end
      S_ANG: state_d = S_PH;
      S_PH:  state_d = S_RD0;
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_W0;
      S_W0:  state_d = S_W1;
      S_W1:  state_d = S_DY;
      S_DY:  state_d = S_DX;
      S_DX:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers, point index and configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      point_idx_q <= '0;
      out_valid_q <= 1'b0;
      wave_kind_q <= WaveSine;
      amp_q       <= AmplitudeRst;
      phase_q     <= '0;
      count_q     <= PointCountRst;
      step_q      <= AngleStepRst;
      inv_q       <= InvTimeStepRst;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        point_idx_q <= is_last_new ? 16'd0 : i_new + 16'd1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWaveKind:    wave_kind_q <= cfg_data_i[0];
          CfgAmplitude:   amp_q       <= cfg_data_i[15:0];
          CfgPhaseOffset: phase_q     <= cfg_data_i;
          CfgPointCount:  count_q     <= cfg_data_i[15:0];
          CfgAngleStep:   step_q      <= cfg_data_i;
          CfgInvTimeStep: inv_q       <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: angles, ROM reads, wave values, products and the output register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      i_q    <= i_new;
      last_q <= is_last_new;
    end
    case (state_q)
      S_ANG: p_q <= mul_p;
      S_PH:  ang_q <= p_q[ANGLE_BITS-1:0] + phase_ext;
      S_RD0: begin
        rom_q <= SINE_ROM[rom_addr];
        ang_q <= ang_q + step_ext;
      end
      S_RD1: begin
        rom_q <= SINE_ROM[rom_addr];
        s0_q  <= rom_q;
        p_q   <= mul_p;
      end
      S_W0: begin
        w0_q <= wave_val(wave_kind_q, amp_q, p_q, s0_q);
        p_q  <= mul_p;
      end
      S_W1: d_q <= {w1[16], w1} - {w0_q[16], w0_q};
      S_DY: p_q <= mul_p;
      S_DX: begin
        y_q <= y_sat;
        p_q <= mul_p;
      end
      S_OUT: begin
        if (out_free) begin
          x_out_q    <= last_q ? '0 : x_sat;
          y_out_q    <= last_q ? '0 : y_q;
          last_out_q <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/waveform_velocity_generator_test.sv
// Self-checking testbench for the waveform velocity generator: directed and random
// tick transactions under random sender bursts and receiver stalls, checked by a predictor.
// Depends on wvg_pkg and the waveform_velocity_generator RTL.
`timescale 1ns / 1ps

module waveform_velocity_generator_test;
  import wvg_pkg::*;

  localparam int TableDepth = TableDepthDef;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam int IdleLimit = 2000;
  localparam int RandomItems = 1700;
  localparam int LongHold = 250;

  // One result transaction as the block should produce it.
  typedef struct packed {
    logic [XVelW-1:0] x;
    logic [YVelW-1:0] y;
    logic             last;
  } velocity_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic restart = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [XVelW-1:0] x_velocity_o;
  logic signed [YVelW-1:0] y_velocity_o;
  logic is_last_o;

  // Ticks waiting to be offered and velocities waiting to come out.
  logic pending_ticks[$];
  velocity_t velocity_q[$];
  velocity_t want;
  logic next_restart;
  int mismatches = 0;
  int hold_requests = 0;
  int holds_done;
  int burst_left;
  int gap_left;
  int hold_left;
  int stall_mode;
  int mode_left;
  int idle_cycles;

  // Shadow copy of the block's registers, point index and sine ROM.
  logic signed [15:0] sine_rom[TableDepth];
  logic               cfg_kind;
  logic signed [15:0] cfg_amp;
  logic [23:0]        cfg_phase;
  logic [15:0]        cfg_points;
  logic [23:0]        cfg_step;
  logic [15:0]        cfg_inv;
  logic [15:0]        point_idx;

  waveform_velocity_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .x_velocity_o (x_velocity_o),
    .y_velocity_o (y_velocity_o),
    .is_last_o    (is_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Rounded 32767*sin(2*pi*j/depth) from a Q30 Taylor series over one quadrant.
  function automatic logic signed [15:0] sine_entry(int unsigned j);
    longint unsigned u, q, r, x, x2, term, s;
    int k;
    u = 4 * longint'(j);
    q = u / TableDepth;
    r = u % TableDepth;
    if (q[0]) begin
      r = TableDepth - r;
    end
    x = (r * HalfPiQ30) / TableDepth;
    x2 = (x * x) >> 30;
    term = x;
    s = x;
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    s = (64'd32767 * s + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return (q >= 2) ? 16'(-s) : 16'(s);
  endfunction

  // Wave height at point k for the current settings.
  function automatic longint wave_level(logic [15:0] k);
    longint unsigned turn;
    logic [23:0] angle;
    longint s;
    turn = longint'(k) * longint'(cfg_step) + longint'(cfg_phase);
    angle = turn[23:0];
    s = longint'(sine_rom[angle[23:12]]);
    if (cfg_kind == WaveSquare) begin
      if (s > 0) begin
        return longint'(cfg_amp);
      end
      if (s < 0) begin
        return -longint'(cfg_amp);
      end
      return 0;
    end
    return (longint'(cfg_amp) * s) >>> 15;
  endfunction

  // Velocity for one tick; advances the shadow point index.
  function automatic velocity_t next_velocity(logic restart_tick);
    velocity_t v;
    longint unsigned xr;
    longint yr;
    if (restart_tick) begin
      point_idx = '0;
    end
    if (32'(point_idx) + 1 >= 32'(cfg_points)) begin
      v.x = '0;
      v.y = '0;
      v.last = 1'b1;
      point_idx = '0;
    end else begin
      xr = (longint'(cfg_step) * longint'(cfg_inv)) >> 8;
      if (xr > 64'h7FFF_FFFF) begin
        xr = 64'h7FFF_FFFF;
      end
      yr = ((wave_level(point_idx + 16'd1) - wave_level(point_idx)) * longint'(cfg_inv)) >>> 8;
      if (yr > 64'sd16777215) begin
        yr = 64'sd16777215;
      end
      if (yr < -64'sd16777216) begin
        yr = -64'sd16777216;
      end
      v.x = xr[XVelW-1:0];
      v.y = yr[YVelW-1:0];
      v.last = 1'b0;
      point_idx = point_idx + 16'd1;
    end
    return v;
  endfunction

  // One register write on the next edge; the shadow copy follows at once.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CfgWaveKind:    cfg_kind = data[0];
      CfgAmplitude:   cfg_amp = data[15:0];
      CfgPhaseOffset: cfg_phase = data[23:0];
      CfgPointCount:  cfg_points = data[15:0];
      CfgAngleStep:   cfg_step = data[23:0];
      CfgInvTimeStep: cfg_inv = data[15:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Block until nothing is offered, queued or outstanding.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_ticks.size() != 0 || in_valid || velocity_q.size() != 0);
  endtask

  // Random settings, with the extremes of each register weighted in.
  task automatic randomize_setup();
    logic [15:0] pts;
    logic [23:0] stp;
    logic [15:0] val16;
    logic [23:0] val24;
    pts = cfg_points;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0: pts = 16'd3;
        1: pts = 16'hFFFF;
        2, 3: pts = 16'($urandom_range(41, 2000));
        default: pts = 16'($urandom_range(3, 40));
      endcase
      write_reg(CfgPointCount, {8'd0, pts});
    end
    if ($urandom_range(0, 3) != 0) begin
      write_reg(CfgWaveKind, 24'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0: val16 = 16'h7FFF;
        1: val16 = 16'h8000;
        2: val16 = 16'h0000;
        default: val16 = 16'($urandom);
      endcase
      write_reg(CfgAmplitude, {8'd0, val16});
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0: val24 = 24'd0;
        1: val24 = 24'hFFFFFF;
        default: val24 = 24'($urandom);
      endcase
      write_reg(CfgPhaseOffset, val24);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0: stp = 24'd0;
        1: stp = 24'd8388608;
        2: stp = 24'hFFFFFF;
        3, 4, 5: stp = 24'(32'd16777216 / (32'(pts) - 1));
        default: stp = 24'($urandom_range(0, 8388608));
      endcase
      write_reg(CfgAngleStep, stp);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0: val16 = 16'd0;
        1: val16 = 16'hFFFF;
        2: val16 = 16'd256;
        default: val16 = 16'($urandom);
      endcase
      write_reg(CfgInvTimeStep, {8'd0, val16});
    end
    close_writes();
  endtask

  // Sender: bursts of tick transactions with random gaps, fed from pending_ticks.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      restart <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        velocity_q.push_back(next_velocity(restart));
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_restart = pending_ticks.pop_front();
          in_valid <= 1'b1;
          restart <= next_restart;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls on its own pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      holds_done <= 0;
      hold_left <= 0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (velocity_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual x %0d y %0d last %0b",
                   $time, x_velocity_o, y_velocity_o, is_last_o);
        end else begin
          want = velocity_q.pop_front();
          if (x_velocity_o !== want.x) begin
            mismatches++;
            $display("%0t: x_velocity expected %0d, actual %0d", $time, want.x, x_velocity_o);
          end
          if (y_velocity_o !== want.y) begin
            mismatches++;
            $display("%0t: y_velocity expected %0d, actual %0d", $time,
                     $signed(want.y), y_velocity_o);
          end
          if (is_last_o !== want.last) begin
            mismatches++;
            $display("%0t: is_last expected %0b, actual %0b", $time, want.last, is_last_o);
          end
        end
      end
      // A requested long hold-off takes priority over the random pattern.
      if (holds_done != hold_requests) begin
        holds_done <= holds_done + 1;
        hold_left <= LongHold;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left <= $urandom_range(16, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[waveform_velocity_generator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int count;
    int random_total;
    int phase_no;
    idle_cycles = 0;
    for (n = 0; n < TableDepth; n++) begin
      sine_rom[n] = sine_entry(n);
    end
    cfg_kind = WaveSine;
    cfg_amp = AmplitudeRst;
    cfg_phase = '0;
    cfg_points = PointCountRst;
    cfg_step = AngleStepRst;
    cfg_inv = InvTimeStepRst;
    point_idx = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: the first points of the default period.
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    wait_idle();

    // Largest amplitude and slope, a half-turn step and a phase next to the angle wrap;
    // the index is already past a three point period.
    write_reg(CfgWaveKind, {23'd0, WaveSine});
    write_reg(CfgAmplitude, 24'h007FFF);
    write_reg(CfgPhaseOffset, 24'hFFFFFF);
    write_reg(CfgPointCount, 24'd3);
    write_reg(CfgAngleStep, 24'd8388608);
    write_reg(CfgInvTimeStep, 24'h00FFFF);
    close_writes();
    repeat (4) pending_ticks.push_back(1'b0);
    wait_idle();

    // Square wave at its most negative amplitude, sitting on a zero table entry.
    write_reg(CfgWaveKind, {23'd0, WaveSquare});
    write_reg(CfgAmplitude, 24'h008000);
    write_reg(CfgPhaseOffset, 24'd0);
    write_reg(CfgPointCount, 24'd8);
    write_reg(CfgAngleStep, 24'd0);
    close_writes();
    pending_ticks.push_back(1'b1);
    repeat (4) pending_ticks.push_back(1'b0);
    wait_idle();

    // Period shortened below the current index; oversized step saturates x.
    write_reg(CfgPointCount, 24'd3);
    write_reg(CfgAngleStep, 24'hFFFFFF);
    write_reg(CfgAmplitude, 24'h007FFF);
    write_reg(CfgPhaseOffset, 24'd12345);
    close_writes();
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    wait_idle();

    // Zero inverse time step with a step of one.
    write_reg(CfgWaveKind, {23'd0, WaveSine});
    write_reg(CfgAmplitude, 24'h008000);
    write_reg(CfgAngleStep, 24'd1);
    write_reg(CfgInvTimeStep, 24'd0);
    close_writes();
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);

    // Random phases; each starts only after every result of the previous one.
    random_total = 0;
    phase_no = 0;
    while (random_total < RandomItems) begin
      wait_idle();
      randomize_setup();
      count = $urandom_range(10, 120);
      if (phase_no % 7 == 3) begin
        count = 120;
        hold_requests++;
      end
      for (n = 0; n < count; n++) begin
        pending_ticks.push_back($urandom_range(0, 15) == 0);
      end
      random_total += count;
      phase_no++;
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && velocity_q.size() == 0) begin
      $display("[waveform_velocity_generator] OK");
    end else begin
      $display("[waveform_velocity_generator] ERROR");
    end
    $finish;
  end

endmodule
